FILE: src/tbdeb_pkg.sv
// Shared constants, codes and types for the trackball direction debouncer.
package tbdeb_pkg;

  localparam int TIME_WIDTH_DEFAULT  = 48;
  localparam int COUNT_WIDTH_DEFAULT = 32;

  localparam int PERCENT_WIDTH = 9;
  localparam int WINDOW_WIDTH  = 16;
  localparam int APB_WIDTH     = 32;
  localparam int ADDR_WIDTH    = 3;

  localparam logic [PERCENT_WIDTH-1:0] PERCENT_MIN   = PERCENT_WIDTH'(25);
  localparam logic [PERCENT_WIDTH-1:0] PERCENT_MAX   = PERCENT_WIDTH'(300);
  localparam logic [PERCENT_WIDTH-1:0] PERCENT_RESET = PERCENT_WIDTH'(100);

  localparam int WINDOW_NUMERATOR = 1200000;
  localparam int NUM_BITS         = $clog2(WINDOW_NUMERATOR + 1);
  localparam int STEP_WIDTH       = $clog2(NUM_BITS);

  localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET =
    WINDOW_WIDTH'(WINDOW_NUMERATOR / 100);

  localparam logic [ADDR_WIDTH-1:0] ADDR_SPEED = ADDR_WIDTH'(0);

  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_KEYBOARD = 3'd1;
  localparam logic [2:0] KIND_RESYNC   = 3'd2;
  localparam logic [2:0] KIND_UP       = 3'd3;
  localparam logic [2:0] KIND_DOWN     = 3'd4;
  localparam logic [2:0] KIND_RIGHT    = 3'd5;
  localparam logic [2:0] KIND_LEFT     = 3'd6;

  typedef enum logic [1:0] {
    REASON_ACCEPTED   = 2'd0,
    REASON_KEYBOARD   = 2'd1,
    REASON_NOT_DIR    = 2'd2,
    REASON_SUPPRESSED = 2'd3
  } reason_t;

  typedef struct packed {
    logic                     start;
    logic [PERCENT_WIDTH-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic [WINDOW_WIDTH-1:0] quotient;
  } div_resp_t;

endpackage

FILE: src/tbdeb_window_div.sv
// Bit-serial restoring divider that turns the speed percent into the window length.
module tbdeb_window_div (
  input  logic                clk,
  input  logic                rst,
  input  tbdeb_pkg::div_req_t  req,
  output tbdeb_pkg::div_resp_t resp
);
  import tbdeb_pkg::*;

  logic                     busy;
  logic                     done;
  logic [STEP_WIDTH-1:0]    step;
  logic [PERCENT_WIDTH-1:0] rem;
  logic [PERCENT_WIDTH-1:0] divisor;
  logic [NUM_BITS-1:0]      work;

  logic [PERCENT_WIDTH:0]   trial;
  logic [PERCENT_WIDTH:0]   trial_diff;
  logic                     fits;

  always_comb begin
    trial      = {rem, work[NUM_BITS-1]};
    trial_diff = trial - {1'b0, divisor};
    fits       = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && step == STEP_WIDTH'(NUM_BITS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      step    <= '0;
      rem     <= '0;
      divisor <= req.divisor;
      work    <= NUM_BITS'(WINDOW_NUMERATOR);
    end else if (busy) begin
      step <= step + STEP_WIDTH'(1);
      rem  <= fits ? trial_diff[PERCENT_WIDTH-1:0] : trial[PERCENT_WIDTH-1:0];
      work <= {work[NUM_BITS-2:0], fits};
    end
  end

  assign resp.busy     = busy;
  assign resp.done     = done;
  assign resp.quotient = work[WINDOW_WIDTH-1:0];

endmodule

FILE: src/trackball_direction_debouncer.sv
// Top level: per-direction timestamp window debounce with event counters.
// An accepted word is registered in s1, then its result in the output register.
// One word per cycle unless the output stalls or a speed write is in progress; results are
// held in an output register. A speed_percent write starts the serial window divider; input
// is stalled from the write's access cycle while it runs, and window_us loads on its done.
// Reset (rst, synchronous): stored times and counters cleared, speed 100, window 12000.
module trackball_direction_debouncer #(
  parameter int TIME_WIDTH  = tbdeb_pkg::TIME_WIDTH_DEFAULT,
  parameter int COUNT_WIDTH = tbdeb_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tbdeb_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [tbdeb_pkg::APB_WIDTH-1:0]  pwdata,
  output logic [tbdeb_pkg::APB_WIDTH-1:0]  prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       event_kind,
  input  logic [TIME_WIDTH-1:0]            event_time,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             accepted,
  output logic [1:0]                       direction,
  output logic [1:0]                       reason_code,
  output logic [COUNT_WIDTH-1:0]           raw_edge_total,
  output logic [COUNT_WIDTH-1:0]           suppressed_total,
  output logic [COUNT_WIDTH-1:0]           accepted_total
);
  import tbdeb_pkg::*;

  logic                     cfg_write;
  logic [PERCENT_WIDTH-1:0] pct_raw;
  logic [PERCENT_WIDTH-1:0] pct_clamped;
  logic [PERCENT_WIDTH-1:0] speed_percent;
  logic [WINDOW_WIDTH-1:0]  window_us;
  div_req_t                 div_req;
  div_resp_t                div_resp;

  logic                     s1_valid;
  logic [2:0]               s1_kind;
  logic [TIME_WIDTH-1:0]    s1_ts;
  logic                     s1_advance;

  logic [TIME_WIDTH-1:0]    last_time [4];
  logic [COUNT_WIDTH-1:0]   raw_count;
  logic [COUNT_WIDTH-1:0]   supp_count;
  logic [COUNT_WIDTH-1:0]   acc_count;

  logic [1:0]               dir_idx;
  logic [TIME_WIDTH-1:0]    time_diff;
  logic                     is_dir;
  logic                     in_window;
  logic                     pass;
  logic [1:0]               dir_next;
  reason_t                  reason_next;
  logic [COUNT_WIDTH-1:0]   raw_count_next;
  logic [COUNT_WIDTH-1:0]   supp_count_next;
  logic [COUNT_WIDTH-1:0]   acc_count_next;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[ADDR_WIDTH-1] == ADDR_SPEED[ADDR_WIDTH-1]);
  assign pct_raw   = pwdata[PERCENT_WIDTH-1:0];

  always_comb begin
    if (pct_raw < PERCENT_MIN) begin
      pct_clamped = PERCENT_MIN;
    end else if (pct_raw > PERCENT_MAX) begin
      pct_clamped = PERCENT_MAX;
    end else begin
      pct_clamped = pct_raw;
    end
    if (paddr[ADDR_WIDTH-1] == ADDR_SPEED[ADDR_WIDTH-1]) begin
      prdata = APB_WIDTH'(speed_percent);
    end else begin
      prdata = '0;
    end
  end

  assign div_req.start   = cfg_write;
  assign div_req.divisor = pct_clamped;

  tbdeb_window_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_percent <= PERCENT_RESET;
      window_us     <= WINDOW_RESET;
    end else begin
      if (cfg_write) begin
        speed_percent <= pct_clamped;
      end
      if (div_resp.done) begin
        window_us <= div_resp.quotient;
      end
    end
  end

  // input stage
  assign s1_advance = !out_valid || out_ready;
  assign in_ready   = !div_resp.busy && !cfg_write && (!s1_valid || s1_advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_kind <= event_kind;
      s1_ts   <= event_time;
    end
  end

  // window check
  always_comb begin
    dir_idx         = 2'(s1_kind - KIND_UP);
    time_diff       = s1_ts - last_time[dir_idx];
    in_window       = time_diff < TIME_WIDTH'(window_us);
    is_dir          = 1'b0;
    pass            = 1'b0;
    dir_next        = 2'd0;
    reason_next     = REASON_NOT_DIR;
    raw_count_next  = raw_count;
    supp_count_next = supp_count;
    acc_count_next  = acc_count;
    case (s1_kind) inside
      KIND_KEYBOARD, KIND_RESYNC: begin
        reason_next = REASON_KEYBOARD;
      end
      KIND_UP, KIND_DOWN, KIND_RIGHT, KIND_LEFT: begin
        is_dir         = 1'b1;
        dir_next       = dir_idx;
        raw_count_next = raw_count + COUNT_WIDTH'(1);
        if (in_window) begin
          reason_next     = REASON_SUPPRESSED;
          supp_count_next = supp_count + COUNT_WIDTH'(1);
        end else begin
          pass           = 1'b1;
          reason_next    = REASON_ACCEPTED;
          acc_count_next = acc_count + COUNT_WIDTH'(1);
        end
      end
      default: begin
        reason_next = REASON_NOT_DIR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        last_time[i] <= '0;
      end
      raw_count  <= '0;
      supp_count <= '0;
      acc_count  <= '0;
    end else if (s1_valid && s1_advance && is_dir) begin
      if (pass) begin
        last_time[dir_idx] <= s1_ts;
      end
      raw_count  <= raw_count_next;
      supp_count <= supp_count_next;
      acc_count  <= acc_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_advance) begin
      accepted         <= pass;
      direction        <= dir_next;
      reason_code      <= reason_next;
      raw_edge_total   <= raw_count_next;
      suppressed_total <= supp_count_next;
      accepted_total   <= acc_count_next;
    end
  end

endmodule

FILE: src/tbdeb_checker.sv
// Port-level checks for the trackball direction debouncer, bound to the top level.
module tbdeb_checker #(
  parameter int COUNT_WIDTH = tbdeb_pkg::COUNT_WIDTH_DEFAULT
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   accepted,
  input logic [1:0]             direction,
  input logic [1:0]             reason_code,
  input logic [COUNT_WIDTH-1:0] raw_edge_total,
  input logic [COUNT_WIDTH-1:0] suppressed_total,
  input logic [COUNT_WIDTH-1:0] accepted_total
);
  import tbdeb_pkg::*;

  logic out_take;
  assign out_take = out_valid && out_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(reason_code) && $stable(raw_edge_total))
    else $error("result word changed while stalled");

  a_accept_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (accepted == (reason_code == REASON_ACCEPTED)))
    else $error("accepted flag disagrees with reason code");

  a_dir_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (reason_code == REASON_KEYBOARD || reason_code == REASON_NOT_DIR)
      |-> direction == 2'd0)
    else $error("direction set on a non-trackball word");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    out_take ##1 out_take |->
      (raw_edge_total - $past(raw_edge_total)) ==
      ((suppressed_total - $past(suppressed_total)) +
       (accepted_total - $past(accepted_total))))
    else $error("edge count step disagrees with suppressed and accepted steps");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind trackball_direction_debouncer tbdeb_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_tbdeb_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .accepted         (accepted),
  .direction        (direction),
  .reason_code      (reason_code),
  .raw_edge_total   (raw_edge_total),
  .suppressed_total (suppressed_total),
  .accepted_total   (accepted_total)
);

FILE: test/trackball_direction_debouncer_checker.sv
// Checker for the trackball debouncer: predicts each result word and compares it.
`timescale 1ns / 100ps

module trackball_direction_debouncer_checker #(
  parameter int TIME_WIDTH  = tbdeb_pkg::TIME_WIDTH_DEFAULT,
  parameter int COUNT_WIDTH = tbdeb_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tbdeb_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [tbdeb_pkg::APB_WIDTH-1:0]  pwdata,
  input  logic [tbdeb_pkg::APB_WIDTH-1:0]  prdata,
  input  logic                             pready,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [2:0]                       event_kind,
  input  logic [TIME_WIDTH-1:0]            event_time,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic                             accepted,
  input  logic [1:0]                       direction,
  input  logic [1:0]                       reason_code,
  input  logic [COUNT_WIDTH-1:0]           raw_edge_total,
  input  logic [COUNT_WIDTH-1:0]           suppressed_total,
  input  logic [COUNT_WIDTH-1:0]           accepted_total,
  output int                               fail_count,
  output int                               outstanding,
  output int                               results_seen,
  output int                               passed_seen,
  output int                               held_seen
);
  import tbdeb_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic                   passed;
    logic [1:0]             dir;
    reason_t                reason;
    logic [COUNT_WIDTH-1:0] edges;
    logic [COUNT_WIDTH-1:0] held;
    logic [COUNT_WIDTH-1:0] passes;
  } debounce_result_t;

  logic [TIME_WIDTH-1:0]   last_pass_time [4];
  logic [WINDOW_WIDTH-1:0] window;
  logic [PERCENT_WIDTH-1:0] speed;
  logic [COUNT_WIDTH-1:0]  edge_count;
  logic [COUNT_WIDTH-1:0]  held_count;
  logic [COUNT_WIDTH-1:0]  pass_count;

  debounce_result_t pending_results [$];

  initial begin
    fail_count   = 0;
    outstanding  = 0;
    results_seen = 0;
    passed_seen  = 0;
    held_seen    = 0;
  end

  function automatic debounce_result_t debounce_event(input logic [2:0] kind,
                                                      input logic [TIME_WIDTH-1:0] stamp);
    debounce_result_t r;
    logic [1:0] lane;
    logic [TIME_WIDTH-1:0] elapsed;
    r = '0;
    r.reason = REASON_NOT_DIR;
    if (kind == KIND_KEYBOARD || kind == KIND_RESYNC) begin
      r.reason = REASON_KEYBOARD;
    end else if (kind >= KIND_UP && kind <= KIND_LEFT) begin
      lane = 2'(kind - KIND_UP);
      elapsed = stamp - last_pass_time[lane];
      r.dir = lane;
      edge_count = edge_count + 1'b1;
      if (elapsed < TIME_WIDTH'(window)) begin
        held_count = held_count + 1'b1;
        r.reason = REASON_SUPPRESSED;
      end else begin
        last_pass_time[lane] = stamp;
        pass_count = pass_count + 1'b1;
        r.passed = 1'b1;
        r.reason = REASON_ACCEPTED;
      end
    end
    r.edges  = edge_count;
    r.held   = held_count;
    r.passes = pass_count;
    return r;
  endfunction

  function automatic string describe(input debounce_result_t r);
    return $sformatf("acc=%0b dir=%0d reason=%0d edges=%0d suppressed=%0d accepted=%0d",
                     r.passed, r.dir, r.reason, r.edges, r.held, r.passes);
  endfunction

  task automatic log_fault(input string text);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("[%0t] %s", $realtime, text);
  endtask

  always @(posedge clk) begin : track
    debounce_result_t want;
    debounce_result_t got;
    logic [PERCENT_WIDTH-1:0] pct;
    if (rst) begin
      for (int i = 0; i < 4; i++) last_pass_time[i] = '0;
      window     = WINDOW_RESET;
      speed      = PERCENT_RESET;
      edge_count = '0;
      held_count = '0;
      pass_count = '0;
      pending_results.delete();
    end else begin
      if (psel && penable && pready && paddr == ADDR_SPEED) begin
        if (pwrite) begin
          pct = pwdata[PERCENT_WIDTH-1:0];
          if (pct < PERCENT_MIN) pct = PERCENT_MIN;
          if (pct > PERCENT_MAX) pct = PERCENT_MAX;
          speed  = pct;
          window = WINDOW_WIDTH'(WINDOW_NUMERATOR / int'(pct));
        end else if (prdata !== APB_WIDTH'(speed)) begin
          log_fault($sformatf("speed read: expected %0d, got %0d", speed, prdata));
        end
      end
      if (in_valid && in_ready) pending_results.push_back(debounce_event(event_kind, event_time));
      if (out_valid && out_ready) begin
        got = '{accepted, direction, reason_t'(reason_code),
                raw_edge_total, suppressed_total, accepted_total};
        results_seen++;
        if (pending_results.size() == 0) begin
          log_fault($sformatf("unexpected word: got %s", describe(got)));
        end else begin
          want = pending_results.pop_front();
          if (want.reason == REASON_ACCEPTED) passed_seen++;
          if (want.reason == REASON_SUPPRESSED) held_seen++;
          if (got.passed !== want.passed || got.dir !== want.dir ||
              got.reason !== want.reason || got.edges !== want.edges ||
              got.held !== want.held || got.passes !== want.passes)
            log_fault($sformatf("word %0d: expected %s, got %s",
                                results_seen, describe(want), describe(got)));
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

FILE: test/tb_trackball_direction_debouncer.sv
// Testbench top for the trackball debouncer: drives events and speed writes, gives the verdict.
`timescale 1ns / 100ps

module tb_trackball_direction_debouncer;
  import tbdeb_pkg::*;

  localparam int TIME_WIDTH     = TIME_WIDTH_DEFAULT;
  localparam int COUNT_WIDTH    = COUNT_WIDTH_DEFAULT;
  localparam int PHASE_EVENTS   = 165;
  localparam int WRITE_COUNT    = 10;
  localparam int SETTLE_CYCLES  = 30;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [2:0]            KIND_SPARE  = 3'd7;
  localparam logic [ADDR_WIDTH-1:0] ADDR_UNUSED = ADDR_WIDTH'(4);

  localparam logic [APB_WIDTH-1:0] SPEED_WORDS [WRITE_COUNT-1] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'd24, 32'd25, 32'd300,
    32'd301, 32'd511, 32'd612, 32'd150
  };

  logic                   clk;
  logic                   rst          = 1'b1;
  logic                   psel         = 1'b0;
  logic                   penable      = 1'b0;
  logic                   pwrite       = 1'b0;
  logic [ADDR_WIDTH-1:0]  paddr        = '0;
  logic [APB_WIDTH-1:0]   pwdata       = '0;
  logic [APB_WIDTH-1:0]   prdata;
  logic                   pready;
  logic                   in_valid     = 1'b0;
  logic                   in_ready;
  logic [2:0]             event_kind   = KIND_NONE;
  logic [TIME_WIDTH-1:0]  event_time   = '0;
  logic                   out_valid;
  logic                   out_ready    = 1'b0;
  logic                   accepted;
  logic [1:0]             direction;
  logic [1:0]             reason_code;
  logic [COUNT_WIDTH-1:0] raw_edge_total;
  logic [COUNT_WIDTH-1:0] suppressed_total;
  logic [COUNT_WIDTH-1:0] accepted_total;

  int fail_count;
  int outstanding;
  int results_seen;
  int passed_seen;
  int held_seen;

  bit idle_in   = 1'b0;
  bit idle_out  = 1'b0;
  bit hold_due  = 1'b0;
  int quiet_cycles = 0;
  int sent_events  = 0;
  int speed_writes = 0;
  int win = WINDOW_NUMERATOR / 100;
  logic [TIME_WIDTH-1:0] now = '0;

  trackball_direction_debouncer #(
    .TIME_WIDTH (TIME_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .event_kind(event_kind), .event_time(event_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .accepted(accepted), .direction(direction), .reason_code(reason_code),
    .raw_edge_total(raw_edge_total), .suppressed_total(suppressed_total),
    .accepted_total(accepted_total)
  );

  trackball_direction_debouncer_checker #(
    .TIME_WIDTH (TIME_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .event_kind(event_kind), .event_time(event_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .accepted(accepted), .direction(direction), .reason_code(reason_code),
    .raw_edge_total(raw_edge_total), .suppressed_total(suppressed_total),
    .accepted_total(accepted_total),
    .fail_count(fail_count), .outstanding(outstanding),
    .results_seen(results_seen), .passed_seen(passed_seen), .held_seen(held_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("trackball_direction_debouncer: mismatch");
        $finish;
      end
    end
  end

  task automatic send_event(input logic [2:0] kind, input logic [TIME_WIDTH-1:0] stamp);
    int gap;
    gap = idle_in ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    event_kind <= kind;
    event_time <= stamp;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent_events++;
  endtask

  task automatic apb_access(input bit write, input logic [ADDR_WIDTH-1:0] addr,
                            input logic [APB_WIDTH-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic pick_event(output logic [2:0] kind, output logic [TIME_WIDTH-1:0] stamp);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      kind = 3'($urandom_range(KIND_UP, KIND_LEFT));
    end else begin
      case ($urandom_range(0, 3))
        0:       kind = KIND_NONE;
        1:       kind = KIND_KEYBOARD;
        2:       kind = KIND_RESYNC;
        default: kind = KIND_SPARE;
      endcase
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      now   = now + TIME_WIDTH'($urandom_range(0, win / 2));
      stamp = now;
    end else if (r < 80) begin
      stamp = now - TIME_WIDTH'($urandom_range(0, win));
    end else if (r < 88) begin
      now   = TIME_WIDTH'({$urandom(), $urandom()});
      stamp = now;
    end else if (r < 94) begin
      now   = '1 - TIME_WIDTH'($urandom_range(0, 2 * win));
      stamp = now;
    end else begin
      stamp = TIME_WIDTH'({$urandom(), $urandom()});
    end
  endtask

  initial begin : receive
    int gap;
    bit held;
    held = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      gap = idle_out ? $urandom_range(0, 9) : 0;
      if (hold_due && !held) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [2:0]            kind;
    logic [TIME_WIDTH-1:0] stamp;
    logic [APB_WIDTH-1:0]  word;
    logic [PERCENT_WIDTH-1:0] pct;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    idle_in  = 1'b1;
    idle_out = 1'b1;
    send_event(KIND_NONE, '0);
    send_event(KIND_KEYBOARD, '1);
    send_event(KIND_RESYNC, 48'h5555_5555_5555);
    send_event(KIND_SPARE, 48'hAAAA_AAAA_AAAA);
    send_event(KIND_UP, '0);
    send_event(KIND_UP, TIME_WIDTH'(WINDOW_RESET) - 1'b1);
    send_event(KIND_UP, TIME_WIDTH'(WINDOW_RESET));
    send_event(KIND_UP, 2 * TIME_WIDTH'(WINDOW_RESET) - 1'b1);
    send_event(KIND_UP, 2 * TIME_WIDTH'(WINDOW_RESET));
    send_event(KIND_DOWN, '1);
    send_event(KIND_DOWN, TIME_WIDTH'(5));
    send_event(KIND_RIGHT, 48'hAAAA_AAAA_AAAA);
    send_event(KIND_RIGHT, 48'hAAAA_AAAA_AAAA);
    send_event(KIND_LEFT, 48'h5555_5555_5555);
    send_event(KIND_LEFT, 48'h5555_5555_5556);
    send_event(KIND_UP, '0);
    for (int k = 0; k < PHASE_EVENTS; k++) begin
      pick_event(kind, stamp);
      send_event(kind, stamp);
    end

    for (int ph = 0; ph < WRITE_COUNT; ph++) begin
      settle();
      word = (ph < WRITE_COUNT - 1) ? SPEED_WORDS[ph] : $urandom();
      apb_access(1'b1, ADDR_SPEED, word);
      apb_access(1'b0, ADDR_SPEED, '0);
      speed_writes++;
      if (ph == 4) begin
        settle();
        apb_access(1'b1, ADDR_UNUSED, 32'd25);
      end
      pct = word[PERCENT_WIDTH-1:0];
      if (pct < PERCENT_MIN) pct = PERCENT_MIN;
      if (pct > PERCENT_MAX) pct = PERCENT_MAX;
      win = WINDOW_NUMERATOR / int'(pct);
      idle_in  = (ph % 3 != 0);
      idle_out = (ph % 3 != 0) && (ph % 4 != 1);
      if (ph == 2) hold_due = 1'b1;
      for (int k = 0; k < PHASE_EVENTS; k++) begin
        pick_event(kind, stamp);
        send_event(kind, stamp);
      end
    end

    settle();
    $display("covered %0d events over %0d speed settings, %0d result words checked",
             sent_events, speed_writes + 1, results_seen);
    $display("%0d passed the window, %0d held back inside it; one long output stall",
             passed_seen, held_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("trackball_direction_debouncer: match");
    end else begin
      $display("trackball_direction_debouncer: mismatch");
    end
    $finish;
  end

endmodule
